// ===== rtl/core/y2rgb_pkg.sv =====
// Shared constants, types and arithmetic helpers for the YUYV to RGB888 converter.
package y2rgb_pkg;

    localparam int PIX_W  = 8;
    localparam int N_PIX  = 2;
    localparam int N_CH   = 3;

    // channel slots
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    localparam logic [7:0] LUMA_OFS   = 8'd16;
    localparam logic [7:0] CHROMA_OFS = 8'd128;

    // reciprocals, exact floor over the magnitudes seen here
    localparam int          RECIP_SHIFT_RNG = 24;
    localparam logic [16:0] RECIP_219       = 17'd76609;   // ceil(2^24/219)
    localparam logic [16:0] RECIP_224       = 17'd74899;   // ceil(2^24/224)
    localparam int          RECIP_SHIFT_MIX = 28;
    localparam logic [18:0] RECIP_1000      = 19'd268436;  // ceil(2^28/1000)

    // BT.601 mixing weights over 1000
    localparam logic signed [19:0] MIX_R_CR = 20'sd1402;
    localparam logic signed [19:0] MIX_G_CB = 20'sd344;
    localparam logic signed [19:0] MIX_G_CR = 20'sd714;
    localparam logic signed [19:0] MIX_B_CB = 20'sd1772;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
    } t_scaled;

    typedef struct packed {
        logic        neg;
        logic [17:0] mag;
    } t_mix_mag;

    // sign and magnitude of 255*(x - ofs)
    function automatic t_scaled scale_255(logic [7:0] x, logic [7:0] ofs);
        logic signed [8:0]  d;
        logic signed [16:0] n;
        t_scaled            s;
        d = $signed({1'b0, x}) - $signed({1'b0, ofs});
        n = (17'(d) <<< 8) - 17'(d);
        s.neg = n[16];
        s.mag = n[16] ? 16'(-n) : n[15:0];
        return s;
    endfunction

    function automatic logic [8:0] div_219(logic [15:0] m);
        logic [32:0] p;
        p = 33'(m) * 33'(RECIP_219);
        return p[RECIP_SHIFT_RNG+8:RECIP_SHIFT_RNG];
    endfunction

    function automatic logic [7:0] div_224(logic [15:0] m);
        logic [32:0] p;
        p = 33'(m) * 33'(RECIP_224);
        return p[RECIP_SHIFT_RNG+7:RECIP_SHIFT_RNG];
    endfunction

    function automatic logic [8:0] div_1000(logic [17:0] m);
        logic [36:0] p;
        p = 37'(m) * 37'(RECIP_1000);
        return p[RECIP_SHIFT_MIX+8:RECIP_SHIFT_MIX];
    endfunction

    function automatic logic [7:0] clamp_byte(logic signed [10:0] v);
        logic [7:0] r;
        if (v[10]) begin
            r = 8'd0;
        end else if (v > 11'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/yuyv_to_rgb888_pair.sv =====
// YUYV macropixel to two RGB888 pixels, BT.601, seven-stage pipeline.
// A taken word passes through the stage registers r1 to r7 in turn on its way to the result ports.
// Throughput: one word per clock; busy never rises, so start may be held high every cycle.
// The rate is set by the pipeline alone: each stage holds one word and nothing loops back.
// Reset (synchronous, active low) clears every stage valid bit; data registers keep garbage.
// o_strobe marks each result for exactly one cycle; the receiver cannot stall.
module yuyv_to_rgb888_pair (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [y2rgb_pkg::PIX_W-1:0] i_luma_first,
    input  logic [y2rgb_pkg::PIX_W-1:0] i_blue_diff,
    input  logic [y2rgb_pkg::PIX_W-1:0] i_luma_second,
    input  logic [y2rgb_pkg::PIX_W-1:0] i_red_diff,
    output logic                        o_strobe,
    output logic [y2rgb_pkg::PIX_W-1:0] o_red_a,
    output logic [y2rgb_pkg::PIX_W-1:0] o_green_a,
    output logic [y2rgb_pkg::PIX_W-1:0] o_blue_a,
    output logic [y2rgb_pkg::PIX_W-1:0] o_red_b,
    output logic [y2rgb_pkg::PIX_W-1:0] o_green_b,
    output logic [y2rgb_pkg::PIX_W-1:0] o_blue_b
);
    import y2rgb_pkg::*;

    // Stage map:
    //  1  offset removal and *255, split into sign and magnitude
    //  2  /219 and /224 on magnitudes by reciprocal multiply
    //  3  sign restored: expanded luma y, chroma pb, pr
    //  4  mixing products, shared by both pixels
    //  5  mixing sums to sign and magnitude
    //  6  /1000 on magnitudes by reciprocal multiply
    //  7  add to each pixel's y, clamp to a byte

    logic                     accept;
    logic [6:0]               r_valid;

    t_scaled                  n1_y  [N_PIX];
    t_scaled                  n1_cb, n1_cr;
    t_scaled                  r1_y  [N_PIX];
    t_scaled                  r1_cb, r1_cr;

    logic [8:0]               n2_yq [N_PIX];
    logic [7:0]               n2_cbq, n2_crq;
    logic                     r2_yneg [N_PIX];
    logic [8:0]               r2_yq   [N_PIX];
    logic                     r2_cbneg, r2_crneg;
    logic [7:0]               r2_cbq, r2_crq;

    logic signed [9:0]        n3_y  [N_PIX];
    logic signed [8:0]        n3_pb, n3_pr;
    logic signed [9:0]        r3_y  [N_PIX];
    logic signed [8:0]        r3_pb, r3_pr;

    logic signed [19:0]       n4_mix [N_CH];
    logic signed [9:0]        r4_y   [N_PIX];
    logic signed [19:0]       r4_mix [N_CH];

    t_mix_mag                 n5_mix [N_CH];
    logic signed [9:0]        r5_y   [N_PIX];
    t_mix_mag                 r5_mix [N_CH];

    logic [8:0]               n6_q   [N_CH];
    logic signed [9:0]        r6_y   [N_PIX];
    logic                     r6_neg [N_CH];
    logic [8:0]               r6_q   [N_CH];

    logic signed [10:0]       n7_sum [N_PIX][N_CH];
    logic [PIX_W-1:0]         r7_rgb [N_PIX][N_CH];

    // no stage ever holds off, so a word is taken whenever start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[5:0], accept};
        end
    end

    // stage 1
    always_comb begin
        n1_y[0] = scale_255(i_luma_first, LUMA_OFS);
        n1_y[1] = scale_255(i_luma_second, LUMA_OFS);
        n1_cb   = scale_255(i_blue_diff, CHROMA_OFS);
        n1_cr   = scale_255(i_red_diff, CHROMA_OFS);
    end

    always_ff @(posedge i_clk) begin
        r1_y  <= n1_y;
        r1_cb <= n1_cb;
        r1_cr <= n1_cr;
    end

    // stage 2
    always_comb begin
        for (int p = 0; p < N_PIX; p++) begin
            n2_yq[p] = div_219(r1_y[p].mag);
        end
        n2_cbq = div_224(r1_cb.mag);
        n2_crq = div_224(r1_cr.mag);
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < N_PIX; p++) begin
            r2_yneg[p] <= r1_y[p].neg;
            r2_yq[p]   <= n2_yq[p];
        end
        r2_cbneg <= r1_cb.neg;
        r2_crneg <= r1_cr.neg;
        r2_cbq   <= n2_cbq;
        r2_crq   <= n2_crq;
    end

    // stage 3: truncation toward zero falls out of dividing the magnitude
    always_comb begin
        for (int p = 0; p < N_PIX; p++) begin
            n3_y[p] = r2_yneg[p] ? 10'(0) - 10'(r2_yq[p]) : 10'(r2_yq[p]);
        end
        n3_pb = r2_cbneg ? 9'(0) - 9'(r2_cbq) : 9'(r2_cbq);
        n3_pr = r2_crneg ? 9'(0) - 9'(r2_crq) : 9'(r2_crq);
    end

    always_ff @(posedge i_clk) begin
        r3_y  <= n3_y;
        r3_pb <= n3_pb;
        r3_pr <= n3_pr;
    end

    // stage 4
    always_comb begin
        n4_mix[CH_R] = 20'(r3_pr) * MIX_R_CR;
        n4_mix[CH_G] = -(20'(r3_pb) * MIX_G_CB) - 20'(r3_pr) * MIX_G_CR;
        n4_mix[CH_B] = 20'(r3_pb) * MIX_B_CB;
    end

    always_ff @(posedge i_clk) begin
        r4_y   <= r3_y;
        r4_mix <= n4_mix;
    end

    // stage 5
    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            n5_mix[c].neg = r4_mix[c][19];
            n5_mix[c].mag = r4_mix[c][19] ? 18'(-r4_mix[c]) : r4_mix[c][17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_y   <= r4_y;
        r5_mix <= n5_mix;
    end

    // stage 6
    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            n6_q[c] = div_1000(r5_mix[c].mag);
        end
    end

    always_ff @(posedge i_clk) begin
        r6_y <= r5_y;
        for (int c = 0; c < N_CH; c++) begin
            r6_neg[c] <= r5_mix[c].neg;
            r6_q[c]   <= n6_q[c];
        end
    end

    // stage 7
    always_comb begin
        for (int p = 0; p < N_PIX; p++) begin
            for (int c = 0; c < N_CH; c++) begin
                n7_sum[p][c] = 11'(r6_y[p])
                             + (r6_neg[c] ? 11'(0) - 11'(r6_q[c]) : 11'(r6_q[c]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < N_PIX; p++) begin
            for (int c = 0; c < N_CH; c++) begin
                r7_rgb[p][c] <= clamp_byte(n7_sum[p][c]);
            end
        end
    end

    assign o_strobe  = r_valid[6];
    assign o_red_a   = r7_rgb[0][CH_R];
    assign o_green_a = r7_rgb[0][CH_G];
    assign o_blue_a  = r7_rgb[0][CH_B];
    assign o_red_b   = r7_rgb[1][CH_R];
    assign o_green_b = r7_rgb[1][CH_G];
    assign o_blue_b  = r7_rgb[1][CH_B];

    // every accepted word surfaces with o_strobe once it has passed through all stages
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_strobe)
        else $error("accepted word did not reach the result ports");

    // equal lumas must give equal pixels: catches lanes crossed or misaligned
    a_lane_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_luma_first == i_luma_second) |-> ##7
        (o_red_a == o_red_b) && (o_green_a == o_green_b) && (o_blue_a == o_blue_b))
        else $error("pixel lanes disagree for equal luma");

    // neutral chroma must give a grey pixel
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_blue_diff == CHROMA_OFS) && (i_red_diff == CHROMA_OFS) |-> ##7
        (o_red_a == o_green_a) && (o_green_a == o_blue_a))
        else $error("neutral chroma produced a colored pixel");

endmodule
